/* design/lmm_pkg.sv */
// Shared types, constants and helpers of the level meter.
package lmm_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_ARE_VOLTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY       = 1'b1;
  localparam logic [31:0] SENS_RESET = 32'h0001_0000;
  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  typedef enum logic [2:0] {
    ST_ACC, ST_DRAIN, ST_LOAD, ST_RUN, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    JOB_MEAN, JOB_MS, JOB_SQRT, JOB_PMAX, JOB_PMIN, JOB_PMEAN, JOB_PRMS
  } job_t;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
    logic emit;
    job_t job;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic done;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -65'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* design/lmm_ctrl.sv */
// Sequencing state machine of the level meter.
module lmm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  input  logic            out_ready,
  input  lmm_pkg::status_t status,
  output logic            in_ready,
  output logic            out_valid,
  output lmm_pkg::cmd_t   cmd
);
  import lmm_pkg::*;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      job_r       <= JOB_MEAN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    case (state_r)
      ST_ACC: begin
        if (in_valid && in_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_LOAD;
          job_nxt   = JOB_MEAN;
        end
      end
      ST_LOAD: state_nxt = ST_RUN;
      ST_RUN: begin
        if (status.done) begin
          state_nxt = ST_LOAD;
          case (job_r)
            JOB_MEAN:  job_nxt = JOB_MS;
            JOB_MS:    job_nxt = JOB_SQRT;
            JOB_SQRT:  job_nxt = JOB_PMAX;
            JOB_PMAX:  job_nxt = JOB_PMIN;
            JOB_PMIN:  job_nxt = JOB_PMEAN;
            JOB_PMEAN: job_nxt = JOB_PRMS;
            default:   state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_ACC;
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_ACC);
    cmd.load  = (state_r == ST_LOAD);
    cmd.step  = (state_r == ST_RUN) && !status.done;
    cmd.store = (state_r == ST_RUN) && status.done;
    cmd.emit  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
    cmd.job   = job_r;
    out_valid = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

endmodule

/* design/lmm_dp.sv */
// Datapath of the level meter: scaling, accumulators, shared divider and root.
module lmm_dp #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned CW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [lmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     in_fire,
  input  logic signed [15:0]       in_sample,
  input  lmm_pkg::cmd_t            cmd,
  output lmm_pkg::status_t         status,
  output logic signed [31:0]       out_max_volt,
  output logic signed [31:0]       out_min_volt,
  output logic signed [31:0]       out_mean_volt,
  output logic [31:0]              out_rms_volt,
  output logic signed [31:0]       out_max_pascal,
  output logic signed [31:0]       out_min_pascal,
  output logic signed [31:0]       out_mean_pascal,
  output logic [31:0]              out_rms_pascal,
  output logic [CW-1:0]            out_sample_count
);
  import lmm_pkg::*;

  localparam int unsigned SW = 33 + $clog2(MAX_SAMPLES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

  logic        volts_r;
  logic [31:0] sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volts_r <= 1'b1;
      sens_r  <= SENS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SAMPLES_ARE_VOLTS) volts_r <= cfg_data[0];
      else if (cfg_index == REG_SENSITIVITY) sens_r <= cfg_data;
    end
  end

  // Accumulation pipeline.
  logic [CW-1:0]        cnt_r;
  logic                 v1_r, v2_r;
  logic signed [31:0]   v_r, max_r, min_r;
  logic signed [SW-1:0] sum_r;
  logic [63:0]          sq_r, sqsum_r;
  logic signed [48:0]   prod;
  logic signed [31:0]   v_nxt;
  logic [64:0]          sqadd;

  assign prod  = in_sample * $signed({1'b0, sens_r});
  assign v_nxt = volts_r ? {in_sample, 16'h0000} : sat32(65'(prod));
  assign sqadd = {1'b0, sqsum_r} + {1'b0, sq_r};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      cnt_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      max_r   <= 32'sh8000_0000;
      min_r   <= 32'sh7FFF_FFFF;
      sum_r   <= '0;
      sqsum_r <= '0;
    end else begin
      v1_r <= in_fire && (cnt_r < CNT_MAX);
      v2_r <= v1_r;
      if (in_fire && (cnt_r < CNT_MAX)) cnt_r <= cnt_r + 1'b1;
      if (v1_r) begin
        if (v_r > max_r) max_r <= v_r;
        if (v_r < min_r) min_r <= v_r;
        sum_r <= sum_r + SW'(v_r);
      end
      if (v2_r) sqsum_r <= sqadd[64] ? {64{1'b1}} : sqadd[63:0];
    end
  end

  always_ff @(posedge clk) begin
    v_r  <= v_nxt;
    sq_r <= 64'(v_r * v_r);
  end

  // Shared restoring divider and digit-by-digit square root.
  logic [6:0]  iter_r;
  logic [63:0] q_r, ms_r;
  logic [31:0] rem_r, den_r;
  logic        neg_r;
  logic [63:0] x_r;
  logic [31:0] root_r;
  logic [35:0] srem_r;
  logic [32:0] dtry;
  logic [35:0] stry, strial;
  logic signed [31:0] pv;
  logic [31:0] pmag;
  logic [SW-1:0] sum_abs;
  logic signed [31:0] mean_r, pmax_r, pmin_r, pmean_r;
  logic [31:0] rms_r, prms_r;
  logic signed [64:0] qsig;
  logic signed [31:0] pas;

  assign dtry    = {rem_r, q_r[63]};
  assign stry    = {srem_r[33:0], x_r[63:62]};
  assign strial  = {2'b00, root_r, 2'b01};
  assign sum_abs = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign qsig    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_comb begin
    case (cmd.job)
      JOB_PMAX:  pv = max_r;
      JOB_PMIN:  pv = min_r;
      default:   pv = mean_r;
    endcase
    pmag = pv[31] ? 32'(-pv) : 32'(pv);
    if (sens_r == 32'd0) begin
      if (neg_r) pas = 32'sh8000_0000;
      else if (pv != 32'sd0) pas = 32'sh7FFF_FFFF;
      else pas = 32'sd0;
    end else begin
      pas = sat32(qsig);
    end
  end

  assign status.done      = (iter_r == 7'd0);
  assign status.pipe_busy = v1_r || v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else if (cmd.load) begin
      iter_r <= (cmd.job == JOB_SQRT) ? SQRT_STEPS : DIV_STEPS;
    end else if (cmd.step) begin
      iter_r <= iter_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= '0;
      srem_r <= '0;
      root_r <= '0;
      x_r    <= ms_r;
      case (cmd.job)
        JOB_MEAN: begin
          q_r   <= 64'(sum_abs);
          den_r <= 32'(cnt_r);
          neg_r <= sum_r[SW-1];
        end
        JOB_MS: begin
          q_r   <= sqsum_r;
          den_r <= 32'(cnt_r);
          neg_r <= 1'b0;
        end
        JOB_PRMS: begin
          q_r   <= {16'h0000, rms_r, 16'h0000};
          den_r <= sens_r;
          neg_r <= 1'b0;
        end
        default: begin
          q_r   <= {16'h0000, pmag, 16'h0000};
          den_r <= sens_r;
          neg_r <= pv[31];
        end
      endcase
    end else if (cmd.step) begin
      if (cmd.job == JOB_SQRT) begin
        x_r <= {x_r[61:0], 2'b00};
        if (stry >= strial) begin
          srem_r <= stry - strial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= stry;
          root_r <= {root_r[30:0], 1'b0};
        end
      end else begin
        if (dtry >= {1'b0, den_r}) begin
          rem_r <= 32'(dtry - {1'b0, den_r});
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= dtry[31:0];
          q_r   <= {q_r[62:0], 1'b0};
        end
      end
    end else if (cmd.store) begin
      case (cmd.job)
        JOB_MEAN:  mean_r  <= sat32(qsig);
        JOB_MS:    ms_r    <= q_r;
        JOB_SQRT:  rms_r   <= root_r;
        JOB_PMAX:  pmax_r  <= pas;
        JOB_PMIN:  pmin_r  <= pas;
        JOB_PMEAN: pmean_r <= pas;
        default: begin
          if (sens_r == 32'd0) prms_r <= (rms_r != 32'd0) ? 32'hFFFF_FFFF : 32'd0;
          else prms_r <= (q_r[63:32] != 32'd0) ? 32'hFFFF_FFFF : q_r[31:0];
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_max_volt     <= max_r;
      out_min_volt     <= min_r;
      out_mean_volt    <= mean_r;
      out_rms_volt     <= rms_r;
      out_max_pascal   <= pmax_r;
      out_min_pascal   <= pmin_r;
      out_mean_pascal  <= pmean_r;
      out_rms_pascal   <= prms_r;
      out_sample_count <= cnt_r;
    end
  end

endmodule

/* design/block_min_max_mean_rms.sv */
// Top level of the block level meter: max, min, mean and RMS of sample blocks.
// Timing: a sample beat is taken each cycle while a block accumulates; after the
// beat marked last the pipeline drains and the seven result jobs run in turn.
// Throughput: one sample a cycle, plus the finalising gap per block, set by the
// shared one-bit-a-cycle divider and the two-bits-a-cycle square root.
// Reset (synchronous, rst_n low): samples_are_volts = 1, sensitivity = 1.0, all
// accumulators cleared, no result pending. No clearing pass is needed.
module block_min_max_mean_rms #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [lmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       in_sample,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       out_max_volt,
  output logic signed [31:0]       out_min_volt,
  output logic signed [31:0]       out_mean_volt,
  output logic [31:0]              out_rms_volt,
  output logic signed [31:0]       out_max_pascal,
  output logic signed [31:0]       out_min_pascal,
  output logic signed [31:0]       out_mean_pascal,
  output logic [31:0]              out_rms_pascal,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] out_sample_count
);
  import lmm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_fire;

  // A sample beat is accepted whenever the controller sits in accumulation; the
  // result register lets a new block start while the last result still waits.
  assign in_fire = in_valid && in_ready;

  lmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .out_ready(out_ready),
    .status   (status),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  // The datapath scales each sample, updates the running statistics through a
  // short pipeline and then works the mean, mean square, root and the four
  // pascal values one after another on a single shared divider and square root.
  lmm_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_fire         (in_fire),
    .in_sample       (in_sample),
    .cmd             (cmd),
    .status          (status),
    .out_max_volt    (out_max_volt),
    .out_min_volt    (out_min_volt),
    .out_mean_volt   (out_mean_volt),
    .out_rms_volt    (out_rms_volt),
    .out_max_pascal  (out_max_pascal),
    .out_min_pascal  (out_min_pascal),
    .out_mean_pascal (out_mean_pascal),
    .out_rms_pascal  (out_rms_pascal),
    .out_sample_count(out_sample_count)
  );

  // A finished block always holds at least one sample.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_count != '0))
    else $error("result beat with zero sample count");

  // The extremes must bracket each other.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_volt <= out_max_volt))
    else $error("min above max");

  // The mean lies between the extremes.
  a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_mean_volt >= out_min_volt) && (out_mean_volt <= out_max_volt)))
    else $error("mean outside min and max");

endmodule

/* sim/block_min_max_mean_rms_tb.sv */
// Self-checking testbench of the block level meter: predicted max, min, mean and RMS results.
`timescale 1ns / 100ps

module block_min_max_mean_rms_tb;
  import lmm_pkg::*;

  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  // The watchdog limit is many times the time a block takes to finalise.
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_max_volt, out_min_volt, out_mean_volt;
  logic [31:0] out_rms_volt;
  logic signed [31:0] out_max_pascal, out_min_pascal, out_mean_pascal;
  logic [31:0] out_rms_pascal;
  logic [CW-1:0] out_sample_count;

  block_min_max_mean_rms #(.MAX_SAMPLES(MAX_SAMPLES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_max_volt(out_max_volt), .out_min_volt(out_min_volt),
    .out_mean_volt(out_mean_volt), .out_rms_volt(out_rms_volt),
    .out_max_pascal(out_max_pascal), .out_min_pascal(out_min_pascal),
    .out_mean_pascal(out_mean_pascal), .out_rms_pascal(out_rms_pascal),
    .out_sample_count(out_sample_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic signed [31:0] max_v, min_v, mean_v;
    logic [31:0] rms_v;
    logic signed [31:0] max_p, min_p, mean_p;
    logic [31:0] rms_p;
    logic [CW-1:0] cnt;
  } level_t;

  // Predictor copy of the configuration and accumulators.
  logic m_volts;
  logic [31:0] m_sens;
  logic signed [31:0] m_max, m_min;
  logic signed [63:0] m_sum;
  logic [63:0] m_sq;
  int unsigned m_cnt;

  level_t levels_due[$];
  int errors = 0;
  int blocks_seen = 0;
  int beats_sent = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic signed [31:0] clip32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -65'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] volts_to_pa(input logic signed [31:0] v);
    logic signed [64:0] n;
    if (m_sens == 0) return (v > 0) ? 32'sh7FFF_FFFF : (v < 0) ? 32'sh8000_0000 : 32'sd0;
    n = 65'(v) * 65'sd65536;
    return clip32(n / $signed({33'd0, m_sens}));
  endfunction

  function automatic logic [31:0] rms_to_pa(input logic [31:0] v);
    logic [63:0] q;
    if (m_sens == 0) return (v != 0) ? 32'hFFFF_FFFF : 32'd0;
    q = ({32'd0, v} << 16) / {32'd0, m_sens};
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic clear_levels();
    m_max = 32'sh8000_0000;
    m_min = 32'sh7FFF_FFFF;
    m_sum = 0;
    m_sq = 0;
    m_cnt = 0;
  endtask

  task automatic predict_level(input logic signed [15:0] s, input logic last);
    logic signed [31:0] v;
    logic signed [63:0] p;
    logic [63:0] sq;
    level_t r;
    if (m_cnt < MAX_SAMPLES) begin
      if (m_volts) v = {s, 16'd0};
      else v = clip32(65'(s) * $signed({33'd0, m_sens}));
      if (v > m_max) m_max = v;
      if (v < m_min) m_min = v;
      m_sum = m_sum + v;
      p = 64'(v) * 64'(v);
      sq = p;
      m_sq = (m_sq > ~64'd0 - sq) ? ~64'd0 : m_sq + sq;
      m_cnt++;
    end
    if (last) begin
      r.max_v = m_max;
      r.min_v = m_min;
      r.mean_v = clip32(65'(m_sum / $signed(64'(m_cnt))));
      r.rms_v = root64(m_sq / 64'(m_cnt));
      r.max_p = volts_to_pa(r.max_v);
      r.min_p = volts_to_pa(r.min_v);
      r.mean_p = volts_to_pa(r.mean_v);
      r.rms_p = rms_to_pa(r.rms_v);
      r.cnt = CW'(m_cnt);
      levels_due.push_back(r);
      clear_levels();
    end
  endtask

  // Sends one sample beat after a random gap, then updates the prediction.
  // Valid is only dropped when a gap follows, so a back-to-back beat needs one drive.
  task automatic send_sample(input logic signed [15:0] s, input logic last);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_level(s, last);
    beats_sent++;
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SAMPLES_ARE_VOLTS) m_volts = val[0];
    else m_sens = val;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_block(input int n);
    for (int i = 0; i < n; i++) send_sample(rand_sample(), i == n - 1);
  endtask

  task automatic test_extremes();
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
  endtask

  task automatic test_scaling();
    write_reg(REG_SAMPLES_ARE_VOLTS, 32'd0);
    // Large sensitivity saturates the scaled sample.
    write_reg(REG_SENSITIVITY, 32'hFFFF_FFFF);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh1234, 1'b1);
    // Tiny sensitivity: each scaled sample equals the raw sample value.
    write_reg(REG_SENSITIVITY, 32'd1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // Zero sensitivity: every scaled sample is zero.
    write_reg(REG_SENSITIVITY, 32'd0);
    send_sample(16'sh4000, 1'b0);
    send_sample(-16'sd5, 1'b1);
    write_reg(REG_SAMPLES_ARE_VOLTS, 32'd1);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd9, 1'b1);
    send_sample(16'sd0, 1'b1);
    write_reg(REG_SENSITIVITY, 32'h0001_0000);
  endtask

  task automatic test_random();
    int phase;
    phase = 0;
    while (beats_sent < 1350) begin
      if ((phase % 6) == 5) begin
        write_reg(REG_SAMPLES_ARE_VOLTS, 32'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
          0: write_reg(REG_SENSITIVITY, 32'd1);
          1: write_reg(REG_SENSITIVITY, 32'hFFFF_FFFF);
          default: write_reg(REG_SENSITIVITY, $urandom);
        endcase
      end
      send_block($urandom_range(1, 40));
      phase++;
    end
  endtask

  // Long receiver hold-off while the sender keeps offering short blocks, so that
  // one result waits, the next block finishes behind it and the input stalls.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      repeat (6) send_block(8);
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  // Result receiver: random stalls per beat, checks against the oldest prediction.
  initial begin
    level_t got, want;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_max_volt, out_min_volt, out_mean_volt, out_rms_volt, out_max_pascal,
                out_min_pascal, out_mean_pascal, out_rms_pascal, out_sample_count};
        blocks_seen++;
        if (levels_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = levels_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
        out_ready <= 1'b0;
      end else if (!out_ready && !hold_off && rst_n) begin
        repeat ($urandom_range(0, 4)) @(posedge clk);
        while (hold_off) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    m_volts = 1'b1;
    m_sens = SENS_RESET;
    clear_levels();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_scaling();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d sample beats and checked %0d block results,", beats_sent, blocks_seen);
    $display("across both scaling modes, extreme sensitivities and a long output stall.");
    if (errors == 0 && levels_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
